// ----- hdl/ctts_pkg.sv -----
// ----------------------------------------------------------------------------
// ctts_pkg
// types, sizes and codes shared by the tick scheduler cells and control
// ----------------------------------------------------------------------------
package ctts_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int SLOT_W     = ($clog2(TASK_SLOTS) > 0) ? $clog2(TASK_SLOTS) : 1;
	localparam int MAX_OUT    = 16;
	localparam int CNT_W      = $clog2(MAX_OUT + 1);

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_ADD      = 2'd1,
		KIND_DELETE   = 2'd2,
		KIND_DISPATCH = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] task_tag;
		logic [7:0] first_delay;
		logic [7:0] repeat_period;
		logic [3:0] slot;
	} in_item_t;

	typedef struct packed {
		logic [3:0] slot_out;
		logic [7:0] tag_out;
		logic       ok;
		logic       full_error;
		logic       last;
	} out_item_t;

	// one task slot as held in a cell
	typedef struct packed {
		logic       occupied;
		logic [7:0] tag;
		logic [7:0] delay;
		logic [7:0] period;
		logic [7:0] runs;
	} slot_rec_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tag;
		logic [7:0] first_delay;
		logic [7:0] repeat_period;
		logic       del_hit;
		logic       add_free;
		logic       disp_room;
	} head_ctl_t;

	typedef struct packed {
		logic add_take;
		logic del_was;
		logic disp_take;
	} head_sts_t;

endpackage

// ----- hdl/ctts_cell.sv -----
// ----------------------------------------------------------------------------
// ctts_cell
// one slot register of the rotating task ring, loads from its neighbour
// ----------------------------------------------------------------------------
module ctts_cell
	import ctts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  slot_rec_t d,
	output slot_rec_t q
);

	slot_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

// ----- hdl/ctts_head.sv -----
// ----------------------------------------------------------------------------
// ctts_head
// slot update unit at the head of the ring, applies the current item's
// operation to the slot passing by
// ----------------------------------------------------------------------------
module ctts_head
	import ctts_pkg::*;
(
	input  slot_rec_t cur,
	input  head_ctl_t ctl,
	output slot_rec_t nxt,
	output head_sts_t sts
);

	always_comb begin
		nxt = cur;
		sts = '0;
		case (ctl.kind)
			KIND_TICK: begin
				if (cur.occupied) begin
					if (cur.delay == 8'd0) begin
						if (cur.runs != 8'hFF) nxt.runs = cur.runs + 8'd1;
						if (cur.period != 8'd0) nxt.delay = cur.period;
					end else begin
						nxt.delay = cur.delay - 8'd1;
					end
				end
			end
			KIND_ADD: begin
				if (ctl.add_free && !cur.occupied) begin
					sts.add_take = 1'b1;
					nxt.occupied = 1'b1;
					nxt.tag      = ctl.tag;
					nxt.delay    = ctl.first_delay;
					nxt.period   = ctl.repeat_period;
					nxt.runs     = 8'd0;
				end
			end
			KIND_DELETE: begin
				if (ctl.del_hit) begin
					sts.del_was = cur.occupied;
					nxt = '0;
				end
			end
			KIND_DISPATCH: begin
				if (ctl.disp_room && cur.runs != 8'd0) begin
					sts.disp_take = 1'b1;
					nxt.runs = cur.runs - 8'd1;
					// one-shot task leaves the table once run
					if (cur.period == 8'd0) nxt = '0;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ----- hdl/cooperative_task_tick_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// cooperative_task_tick_scheduler_top
// time-triggered cooperative scheduler built as a rotating ring of slot cells
// ----------------------------------------------------------------------------
// The task table lives in a ring of TASK_SLOTS cells. Every item (tick, add,
// delete or dispatch) turns the ring once, one slot per cycle unless the ring
// is held, past a single update unit at its head, and then closes in the flush
// state with its closing result, if any; a new item is taken only once the
// block is back in idle. A waiting output register holds the ring only when
// a new dispatch result has to leave while the previous one has not yet been
// taken, and the closing result waits in the same way until the output
// register is free. Add and delete give one result each, tick gives none, and
// a dispatch gives one result per pending slot in slot order (at most
// sixteen), or a single empty result when nothing is pending.
// ----------------------------------------------------------------------------
module cooperative_task_tick_scheduler_top
	import ctts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int CMP_W = (SLOT_W > 4) ? SLOT_W : 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	in_item_t          op_q;
	logic [SLOT_W-1:0] step_q;
	logic              found_q;
	logic [3:0]        add_slot_q;
	logic              was_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              hold_valid_q;
	logic [3:0]        hold_slot_q;
	logic [7:0]        hold_tag_q;
	logic              full_q;
	logic              out_valid_q;
	out_item_t         out_q;

	// ring of slot cells, cell 0 is the head
	slot_rec_t cell_q [TASK_SLOTS];
	slot_rec_t head_nxt;
	head_ctl_t ctl;
	head_sts_t sts;
	logic      shift;

	logic [CMP_W-1:0] step_ext;
	logic [CMP_W-1:0] slot_ext;
	logic             out_free;
	logic             emit_hold;
	logic             stall;
	logic             last_step;
	logic             out_load;

	assign step_ext = CMP_W'(step_q);
	assign slot_ext = CMP_W'(op_q.slot);

	assign ctl.kind          = kind_t'(op_q.kind);
	assign ctl.tag           = op_q.task_tag;
	assign ctl.first_delay   = op_q.first_delay;
	assign ctl.repeat_period = op_q.repeat_period;
	assign ctl.del_hit       = (step_ext == slot_ext);
	assign ctl.add_free      = !found_q;
	assign ctl.disp_room     = (cnt_q < CNT_W'(MAX_OUT));

	ctts_head u_head (
		.cur (cell_q[0]),
		.ctl (ctl),
		.nxt (head_nxt),
		.sts (sts)
	);

	// the updated head slot re-enters at the tail, the rest move one on
	genvar gi;
	generate
		for (gi = 0; gi < TASK_SLOTS; gi++) begin : g_ring
			if (gi == TASK_SLOTS - 1) begin : g_tail
				ctts_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.d      (head_nxt),
					.q      (cell_q[gi])
				);
			end else begin : g_body
				ctts_cell u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.shift  (shift),
					.d      (cell_q[gi+1]),
					.q      (cell_q[gi])
				);
			end
		end
	endgenerate

	assign out_free  = !out_valid_q || out_ready;
	// a pending slot pushes out the one held before it, which is not the last
	assign emit_hold = (ctl.kind == KIND_DISPATCH) && sts.disp_take && hold_valid_q;
	assign stall     = emit_hold && !out_free;
	assign shift     = (state_q == ST_RUN) && !stall;
	assign last_step = (step_q == SLOT_W'(TASK_SLOTS - 1));
	// a result enters the output register this cycle
	assign out_load  = (shift && emit_hold) ||
	                   ((state_q == ST_FLUSH) && (ctl.kind != KIND_TICK) && out_free);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= '0;
			step_q       <= '0;
			found_q      <= 1'b0;
			add_slot_q   <= 4'd0;
			was_q        <= 1'b0;
			cnt_q        <= '0;
			hold_valid_q <= 1'b0;
			hold_slot_q  <= 4'd0;
			hold_tag_q   <= 8'd0;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q         <= in_item;
						step_q       <= '0;
						found_q      <= 1'b0;
						was_q        <= 1'b0;
						cnt_q        <= '0;
						hold_valid_q <= 1'b0;
						state_q      <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (shift) begin
						if (sts.add_take) begin
							found_q    <= 1'b1;
							add_slot_q <= 4'(step_q);
						end
						if (ctl.del_hit) was_q <= sts.del_was;
						if (sts.disp_take) begin
							cnt_q        <= cnt_q + CNT_W'(1);
							hold_valid_q <= 1'b1;
							hold_slot_q  <= 4'(step_q);
							hold_tag_q   <= cell_q[0].tag;
						end
						if (emit_hold) begin
							out_q <= '{slot_out: hold_slot_q, tag_out: hold_tag_q,
							           ok: 1'b1, full_error: full_q, last: 1'b0};
						end
						if (last_step) begin
							step_q  <= '0;
							state_q <= ST_FLUSH;
						end else begin
							step_q <= step_q + SLOT_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					// closing result of the item
					if (ctl.kind == KIND_TICK) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						state_q <= ST_IDLE;
						case (ctl.kind)
							KIND_ADD: begin
								if (found_q) begin
									out_q <= '{slot_out: add_slot_q, tag_out: op_q.task_tag,
									           ok: 1'b1, full_error: full_q, last: 1'b1};
								end else begin
									full_q <= 1'b1;
									out_q  <= '{slot_out: 4'd0, tag_out: op_q.task_tag,
									           ok: 1'b0, full_error: 1'b1, last: 1'b1};
								end
							end
							KIND_DELETE: begin
								out_q <= '{slot_out: op_q.slot, tag_out: 8'd0,
								           ok: was_q, full_error: full_q, last: 1'b1};
							end
							KIND_DISPATCH: begin
								if (hold_valid_q) begin
									out_q <= '{slot_out: hold_slot_q, tag_out: hold_tag_q,
									           ok: 1'b1, full_error: full_q, last: 1'b1};
								end else begin
									out_q <= '{slot_out: 4'd0, tag_out: 8'd0,
									           ok: 1'b0, full_error: full_q, last: 1'b1};
								end
							end
							default: begin
								out_q <= '0;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
